### rtl/siaqs_pkg.sv
package siaqs_pkg;

  // Width of the value ports and of the internal sign-extension word
  localparam int unsigned IO_WIDTH  = 32;
  localparam int unsigned EXT_WIDTH = 64;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_SCANL,
    ST_SCANR,
    ST_SWAP_LO,
    ST_SWAP_HI,
    ST_SETTLE,
    ST_PUSH_R,
    ST_PUSH_L,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  // Source of the element store's first read address
  typedef enum logic [1:0] {
    ADDR_SCAN,
    ADDR_MID,
    ADDR_EMIT
  } addr_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;      // store the request's value
    logic      init;      // push the whole set as the first range
    logic      pop;       // pop a range off the stack
    logic      range_ld;  // take the popped range into lo/hi/l/r
    logic      pivot_ld;  // latch the pivot value
    logic      inc_l;     // advance the left scan
    logic      dec_r;     // advance the right scan
    logic      swap_lo;   // write the right element to the left slot
    logic      swap_hi;   // write the left element to the right slot, step both
    logic      push_r;    // push the right part
    logic      push_l;    // push the left part
    logic      emit_adv;  // step the output index
    logic      finish;    // end of run, clear the set
    addr_src_t addr_src;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sp_zero;
    logic scan_l_go;
    logic scan_r_go;
    logic crossed;
    logic emit_last;
  } status_t;

endpackage

### rtl/siaqs_ctrl.sv
module siaqs_ctrl
  import siaqs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    last,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    strobe
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (start && last) state_next = ST_INIT;
      end
      ST_INIT:    state_next = ST_POP;
      ST_POP: begin
        state_next = status.sp_zero ? ST_EMIT_RD : ST_RANGE;
      end
      ST_RANGE:   state_next = ST_PIVOT;
      ST_PIVOT:   state_next = ST_SCANL;
      ST_SCANL: begin
        if (!status.scan_l_go) state_next = ST_SCANR;
      end
      ST_SCANR: begin
        if (!status.scan_r_go) begin
          state_next = status.crossed ? ST_PUSH_R : ST_SWAP_LO;
        end
      end
      ST_SWAP_LO: state_next = ST_SWAP_HI;
      ST_SWAP_HI: state_next = ST_SETTLE;
      ST_SETTLE:  state_next = ST_SCANL;
      ST_PUSH_R:  state_next = ST_PUSH_L;
      ST_PUSH_L:  state_next = ST_POP;
      ST_EMIT_RD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.emit_last) state_next = ST_LOAD;
      end
      default:    state_next = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.addr_src = ADDR_SCAN;
    busy         = 1'b1;
    strobe       = 1'b0;
    case (state)
      ST_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_INIT:    cmd.init = 1'b1;
      ST_POP:     cmd.pop = !status.sp_zero;
      ST_RANGE: begin
        cmd.range_ld = 1'b1;
        cmd.addr_src = ADDR_MID;
      end
      ST_PIVOT:   cmd.pivot_ld = 1'b1;
      ST_SCANL:   cmd.inc_l = status.scan_l_go;
      ST_SCANR:   cmd.dec_r = status.scan_r_go;
      ST_SWAP_LO: cmd.swap_lo = 1'b1;
      ST_SWAP_HI: cmd.swap_hi = 1'b1;
      ST_SETTLE:  cmd = '0;
      ST_PUSH_R:  cmd.push_r = 1'b1;
      ST_PUSH_L:  cmd.push_l = 1'b1;
      ST_EMIT_RD: cmd.addr_src = ADDR_EMIT;
      ST_EMIT: begin
        strobe       = 1'b1;
        cmd.emit_adv = 1'b1;
        cmd.finish   = status.emit_last;
        cmd.addr_src = ADDR_EMIT;
      end
      default:    busy = 1'b1;
    endcase
  end

endmodule

### rtl/siaqs_dp.sv
module siaqs_dp
  import siaqs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS  = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [IO_WIDTH-1:0] value,
  input  cmd_t                       cmd,
  output status_t                    status,
  output logic signed [IO_WIDTH-1:0] value_res,
  output logic                       last_res,
  output logic                       overflowed
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  // Element store and range stack
  logic signed [ELEMENT_WIDTH-1:0] store [MAX_ELEMENTS];
  logic        [2*IW-1:0]          stack [MAX_ELEMENTS];

  logic [CW-1:0] count;
  logic [CW-1:0] sp;
  logic          ovf;

  logic [IW-1:0] lo, hi, l, r, e;
  logic [IW-1:0] l_next, r_next, e_next;
  logic signed [ELEMENT_WIDTH-1:0] pv;
  logic signed [ELEMENT_WIDTH-1:0] rd_a, rd_b;
  logic        [2*IW-1:0]          stk_rd;

  logic [IW-1:0] stk_lo, stk_hi, mid, addr_a, r_c;
  logic [CW-1:0] cnt_m1, sp_m1;
  logic          full, cnt_ge2, push_r_ok, push_l_ok;
  logic signed [EXT_WIDTH-1:0] value_w, res_w;

  assign stk_lo  = stk_rd[2*IW-1:IW];
  assign stk_hi  = stk_rd[IW-1:0];
  assign mid     = stk_lo + ((stk_hi - stk_lo) >> 1);
  assign cnt_m1  = count - CW'(1);
  assign sp_m1   = sp - CW'(1);
  assign full    = (count == CW'(MAX_ELEMENTS));
  assign cnt_ge2 = (count >= CW'(2));

  // Right bound of the left part, clamped below hi
  assign r_c       = (r >= hi) ? (hi - IW'(1)) : r;
  assign push_r_ok = ((r_c + IW'(1)) < hi);
  assign push_l_ok = (r > lo);

  // Next scan indexes; they also address the store so data lines up
  always_comb begin
    l_next = l;
    r_next = r;
    e_next = e;
    if (cmd.range_ld) begin
      l_next = stk_lo;
      r_next = stk_hi;
    end else begin
      if (cmd.inc_l || cmd.swap_hi) l_next = l + IW'(1);
      if (cmd.dec_r || cmd.swap_hi) r_next = r - IW'(1);
      else if (cmd.push_r)          r_next = r_c;
    end
    if (cmd.init)          e_next = '0;
    else if (cmd.emit_adv) e_next = e + IW'(1);
  end

  always_comb begin
    case (cmd.addr_src)
      ADDR_MID:  addr_a = mid;
      ADDR_EMIT: addr_a = e_next;
      default:   addr_a = l_next;
    endcase
  end

  // Input value wrapped to the element width
  assign value_w = EXT_WIDTH'(value);

  // Element store: one write port, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      store[count[IW-1:0]] <= value_w[ELEMENT_WIDTH-1:0];
    end else if (cmd.swap_lo) begin
      store[l] <= rd_b;
    end else if (cmd.swap_hi) begin
      store[r] <= rd_a;
    end
    rd_a <= store[addr_a];
    rd_b <= store[r_next];
  end

  // Range stack: one write port, registered read of the top entry
  always_ff @(posedge clk) begin
    if (cmd.init && cnt_ge2) begin
      stack[0] <= {IW'(0), cnt_m1[IW-1:0]};
    end else if (cmd.push_r && push_r_ok) begin
      stack[sp[IW-1:0]] <= {r_c + IW'(1), hi};
    end else if (cmd.push_l && push_l_ok) begin
      stack[sp[IW-1:0]] <= {lo, r};
    end
    stk_rd <= stack[sp_m1[IW-1:0]];
  end

  // Working registers
  always_ff @(posedge clk) begin
    l <= l_next;
    r <= r_next;
    e <= e_next;
    if (cmd.range_ld) begin
      lo <= stk_lo;
      hi <= stk_hi;
    end
    if (cmd.pivot_ld) pv <= rd_a;
  end

  // Count, stack pointer, overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sp    <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) ovf <= 1'b1;
        else      count <= count + CW'(1);
      end
      if (cmd.init) begin
        sp <= cnt_ge2 ? CW'(1) : '0;
      end else if (cmd.pop) begin
        sp <= sp_m1;
      end else if ((cmd.push_r && push_r_ok) || (cmd.push_l && push_l_ok)) begin
        sp <= sp + CW'(1);
      end
      if (cmd.finish) begin
        count <= '0;
        sp    <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Status
  assign status.sp_zero   = (sp == '0);
  assign status.scan_l_go = (l < hi) && (rd_a < pv);
  assign status.scan_r_go = (r > lo) && (rd_b > pv);
  assign status.crossed   = (l >= r);
  assign status.emit_last = (CW'(e) == cnt_m1);

  // Result fields
  assign res_w      = EXT_WIDTH'(rd_a);
  assign value_res  = res_w[IO_WIDTH-1:0];
  assign last_res   = status.emit_last;
  assign overflowed = ovf;

endmodule

### rtl/signed_int_array_quicksort_core.sv
// Loading: one request per cycle while busy is low; an item marked last starts the sort.
// Sort time is data dependent: each popped range takes the pop, range and pivot states,
// then the scan steps (the stopping step included), exchanges (swap lo, swap hi, settle)
// and the right and left stack pushes; the first push and the final empty pop come on top.
// Then a bubble state and one result per cycle, strobe high; busy drops after the last. The receiver cannot stall.
// Reset (rst, synchronous) empties the set, clears the overflow flag and returns to loading.
module signed_int_array_quicksort_core
  import siaqs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS  = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [IO_WIDTH-1:0] value,
  input  logic                       last,
  output logic                       strobe,
  output logic signed [IO_WIDTH-1:0] value_res,
  output logic                       last_res,
  output logic                       overflowed
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  siaqs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  // Store, stack and compare datapath
  siaqs_dp #(
    .MAX_ELEMENTS  (MAX_ELEMENTS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .value_res  (value_res),
    .last_res   (last_res),
    .overflowed (overflowed)
  );

endmodule

### dv/signed_int_array_quicksort_core_tb.sv
`timescale 1ns / 1ps

module signed_int_array_quicksort_core_tb;
  import siaqs_pkg::*;

  localparam int MAX_ELEMS = 64;
  localparam int SPAN_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 16;
  localparam logic signed [IO_WIDTH-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [IO_WIDTH-1:0] MAX_VAL = 32'sh7fff_ffff;

  // value patterns for random sets
  localparam int PAT_FULL = 0;
  localparam int PAT_DUPS = 1;
  localparam int PAT_EXTREME = 2;
  localparam int PAT_RAMP = 3;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] val;
    logic is_last;
    logic ovf;
  } sorted_elem_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [IO_WIDTH-1:0] value = '0;
  logic last = 1'b0;
  logic busy;
  logic strobe;
  logic signed [IO_WIDTH-1:0] value_res;
  logic last_res;
  logic overflowed;

  // predictor state: the set being collected
  logic signed [IO_WIDTH-1:0] held [MAX_ELEMS];
  int held_count = 0;
  logic held_ovf = 1'b0;

  sorted_elem_t sorted_expect_q[$];
  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 4;

  signed_int_array_quicksort_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .last(last),
    .strobe(strobe),
    .value_res(value_res),
    .last_res(last_res),
    .overflowed(overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hoare-partition quicksort of the held set, left part first
  function automatic void sort_held();
    int span_lo [SPAN_DEPTH];
    int span_hi [SPAN_DEPTH];
    int sp;
    int lo;
    int hi;
    int piv;
    int l;
    int r;
    logic signed [IO_WIDTH-1:0] t;
    sp = 0;
    if (held_count >= 2) begin
      span_lo[0] = 0;
      span_hi[0] = held_count - 1;
      sp = 1;
    end
    while (sp > 0) begin
      sp--;
      lo = span_lo[sp];
      hi = span_hi[sp];
      if (hi >= held_count || lo >= hi) continue;
      piv = lo + (hi - lo) / 2;
      l = lo;
      r = hi;
      while (1) begin
        while (l < hi && held[l] < held[piv]) l++;
        while (r > lo && held[r] > held[piv]) r--;
        if (l >= r) break;
        // pivot position follows its element through the exchange
        if (l == piv) piv = r;
        else if (r == piv) piv = l;
        t = held[l];
        held[l] = held[r];
        held[r] = t;
        l++;
        r--;
      end
      if (r >= hi) r = hi - 1;
      if (hi > r + 1 && sp < SPAN_DEPTH) begin
        span_lo[sp] = r + 1;
        span_hi[sp] = hi;
        sp++;
      end
      if (r > lo && sp < SPAN_DEPTH) begin
        span_lo[sp] = lo;
        span_hi[sp] = r;
        sp++;
      end
    end
  endfunction

  // Update the predictor with one accepted request
  function automatic void predict_request(logic signed [IO_WIDTH-1:0] v, logic l);
    sorted_elem_t e;
    if (held_count < MAX_ELEMS) begin
      held[held_count] = v;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (!l) return;
    sort_held();
    for (int i = 0; i < held_count; i++) begin
      e.val = held[i];
      e.is_last = (i == held_count - 1);
      e.ovf = held_ovf;
      sorted_expect_q.push_back(e);
    end
    held_count = 0;
    held_ovf = 1'b0;
  endfunction

  // Drive one request, hold it until accepted, then maybe idle a while
  task automatic send_request(input logic signed [IO_WIDTH-1:0] v, input logic l);
    int gap;
    start <= 1'b1;
    value <= v;
    last <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(v, l);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      start <= 1'b0;
      value <= $urandom;
      last <= 1'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Hold off until every predicted result has been seen
  task automatic wait_results_drained();
    start <= 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [IO_WIDTH-1:0] pick_value(int pat, int idx, int base);
    case (pat)
      PAT_DUPS: return $urandom_range(0, 6) - 3;
      PAT_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return MIN_VAL;
          1: return MAX_VAL;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
      PAT_RAMP: return base + idx * ((base[0]) ? -3 : 5);
      default: return $urandom;
    endcase
  endfunction

  // Extremes, tiny sets, duplicates and presorted orders
  task automatic test_directed_sets();
    send_request(MIN_VAL, 1'b1);
    send_request(5, 1'b0);
    send_request(-5, 1'b1);
    send_request(MAX_VAL, 1'b0);
    send_request(0, 1'b0);
    send_request(MIN_VAL, 1'b0);
    send_request(-1, 1'b0);
    send_request(1, 1'b0);
    send_request(MIN_VAL + 1, 1'b1);
    for (int i = 0; i < 4; i++) send_request(1234, i == 3);
    for (int i = 0; i < 6; i++) send_request(300 - i * 150, i == 5);
    send_request(MAX_VAL, 1'b1);
  endtask

  // Fill the store, then drop one plain and one last request
  task automatic test_capacity_overflow();
    for (int i = 0; i < MAX_ELEMS + 2; i++) send_request($urandom, i == MAX_ELEMS + 1);
  endtask

  // Random sets: mostly small, now and then near or past capacity
  task automatic test_random_sets(input int target);
    int sent;
    int size;
    int pat;
    int base;
    sent = 0;
    while (sent < target) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      pat = $urandom_range(PAT_FULL, PAT_RAMP);
      base = $urandom;
      for (int i = 0; i < size; i++) send_request(pick_value(pat, i, base), i == size - 1);
      sent += size;
      if ($urandom_range(0, 4) == 0) wait_results_drained();
    end
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk) begin : check_results
    sorted_elem_t want;
    if (!rst && strobe) begin
      if (sorted_expect_q.size() == 0) begin
        $error("unexpected result: value_res %0d last_res %0b overflowed %0b",
               value_res, last_res, overflowed);
        fail_count++;
      end else begin
        want = sorted_expect_q.pop_front();
        if (value_res !== want.val) begin
          $error("value_res: expected %0d, got %0d", want.val, value_res);
          fail_count++;
        end
        if (last_res !== want.is_last) begin
          $error("last_res: expected %0b, got %0b", want.is_last, last_res);
          fail_count++;
        end
        if (overflowed !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
          fail_count++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("signed_int_array_quicksort_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_sets();
    wait_results_drained();
    test_capacity_overflow();
    wait_results_drained();
    test_random_sets(125);
    wait_results_drained();
    if (fail_count == 0) begin
      $display("signed_int_array_quicksort_core regression: pass");
    end else begin
      $display("signed_int_array_quicksort_core regression: fail");
    end
    $finish;
  end

endmodule
